FILE: design/zyxe2t_pkg.sv
// shared constants, tables and helpers for the euler pose to transform block
package zyxe2t_pkg;

  localparam int CORDIC_STAGES    = 20;
  localparam int MATRIX_FRAC_BITS = 20;

  // entry width: sign, integer one, fraction
  localparam int MAT_W = MATRIX_FRAC_BITS + 2;

  // cordic iterations actually built (table has 32 entries)
  localparam int CORDIC_N = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

  // angle unit: four conversion stages, the cordic stages, one sign stage
  localparam int ANG_LAT  = CORDIC_N + 5;
  // matrix stages: products, second products, sums, round and saturate
  localparam int PIPE_LAT = ANG_LAT + 4;

  // shift from 60 fraction bits down to the entry fraction
  localparam int ROUND_SH = 60 - MATRIX_FRAC_BITS;

  localparam logic signed [63:0] MAT_LIM  = 64'sd1 <<< MATRIX_FRAC_BITS;
  localparam logic signed [63:0] ROUND_HF = 64'sd1 <<< (ROUND_SH - 1);

  // cordic start value, gain compensated, 30 fraction bits
  localparam logic signed [33:0] CORDIC_K = 34'sh026DD3B6A;

  // reciprocals of 45 for exact floor division (2^31 and 2^25 scaled)
  localparam logic [25:0] RECIP45_A = 26'd47721859;
  localparam logic [19:0] RECIP45_B = 20'd745655;

  // arctangent of 2^-i in binary angle units (one turn is 2^32)
  localparam logic [31:0] ATAN_BIN [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  // round half up from 60 fraction bits, then clamp to +-1
  function automatic logic [MAT_W-1:0] to_entry(input logic signed [63:0] q);
    logic signed [63:0] v;
    v = (q + ROUND_HF) >>> ROUND_SH;
    if (v > MAT_LIM) begin
      v = MAT_LIM;
    end else if (v < -MAT_LIM) begin
      v = -MAT_LIM;
    end
    return v[MAT_W-1:0];
  endfunction

endpackage

FILE: design/zyxe2t_if.sv
// pose and transform channel interfaces
interface zyxe2t_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [24:0] roll_deg;
  logic signed [24:0] pitch_deg;
  logic signed [24:0] yaw_deg;

  modport source (output valid, pos_x, pos_y, pos_z, roll_deg, pitch_deg, yaw_deg,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, roll_deg, pitch_deg, yaw_deg,
                output ready);
endinterface

interface zyxe2t_xform_if;
  logic                              valid;
  logic                              ready;
  logic signed [zyxe2t_pkg::MAT_W-1:0] m00;
  logic signed [zyxe2t_pkg::MAT_W-1:0] m01;
  logic signed [zyxe2t_pkg::MAT_W-1:0] m02;
  logic signed [zyxe2t_pkg::MAT_W-1:0] m10;
  logic signed [zyxe2t_pkg::MAT_W-1:0] m11;
  logic signed [zyxe2t_pkg::MAT_W-1:0] m12;
  logic signed [zyxe2t_pkg::MAT_W-1:0] m20;
  logic signed [zyxe2t_pkg::MAT_W-1:0] m21;
  logic signed [zyxe2t_pkg::MAT_W-1:0] m22;
  logic signed [31:0]                tx;
  logic signed [31:0]                ty;
  logic signed [31:0]                tz;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  tx, ty, tz, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                tx, ty, tz, output ready);
endinterface

FILE: design/zyxe2t_angle.sv
// degrees to binary angle, then pipelined cordic sine and cosine
module zyxe2t_angle (
  input  logic                               clk,
  input  logic [zyxe2t_pkg::ANG_LAT-1:0]     en_i,
  input  logic signed [24:0]                 deg_i,
  output logic signed [31:0]                 sin_o,
  output logic signed [31:0]                 cos_o
);

  localparam int N = zyxe2t_pkg::CORDIC_N;

  // stage a: magnitude and first reciprocal product
  logic [24:0] abs_w;
  logic [24:0] a_r;
  logic        neg_a_r;
  logic [50:0] prod1_r;

  assign abs_w = deg_i[24] ? (~deg_i + 25'd1) : deg_i;

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      a_r     <= abs_w;
      neg_a_r <= deg_i[24];
      prod1_r <= 51'(abs_w) * 51'(zyxe2t_pkg::RECIP45_A);
    end
  end

  // stage b: quotient and remainder by 45, remainder scaled for second step
  logic [18:0] q1_w;
  logic [24:0] r1_w;
  logic [18:0] q1_b_r;
  logic [18:0] v2_r;
  logic        neg_b_r;

  assign q1_w = prod1_r[49:31];
  assign r1_w = a_r - 25'(q1_w) * 25'd45;

  always_ff @(posedge clk) begin
    if (en_i[1]) begin
      q1_b_r  <= q1_w;
      v2_r    <= {r1_w[5:0], 13'd0} + 19'd22;
      neg_b_r <= neg_a_r;
    end
  end

  // stage c: second reciprocal product
  logic [38:0] prod2_r;
  logic [18:0] q1_c_r;
  logic        neg_c_r;

  always_ff @(posedge clk) begin
    if (en_i[2]) begin
      prod2_r <= 39'(v2_r) * 39'(zyxe2t_pkg::RECIP45_B);
      q1_c_r  <= q1_b_r;
      neg_c_r <= neg_b_r;
    end
  end

  // stage d: signed binary angle, fold into the right half plane
  logic [31:0] q_w;
  logic [31:0] u_w;
  logic [31:0] fold_w;
  logic        flip_w;

  logic signed [33:0] x_r    [0:N];
  logic signed [33:0] y_r    [0:N];
  logic signed [33:0] z_r    [0:N];
  logic               flip_r [0:N];

  assign q_w    = {q1_c_r[18:0], 13'd0} + {19'd0, prod2_r[37:25]};
  assign u_w    = neg_c_r ? (~q_w + 32'd1) : q_w;
  assign fold_w = u_w + 32'h4000_0000;
  assign flip_w = fold_w[31];

  always_ff @(posedge clk) begin
    if (en_i[3]) begin
      x_r[0]    <= zyxe2t_pkg::CORDIC_K;
      y_r[0]    <= '0;
      z_r[0]    <= 34'(signed'(flip_w ? (u_w ^ 32'h8000_0000) : u_w));
      flip_r[0] <= flip_w;
    end
  end

  // cordic rotation stages
  for (genvar j = 0; j < N; j++) begin : g_cordic
    logic signed [33:0] atan_w;
    assign atan_w = signed'({2'b00, zyxe2t_pkg::ATAN_BIN[j]});

    always_ff @(posedge clk) begin
      if (en_i[4+j]) begin
        if (!z_r[j][33]) begin
          x_r[j+1] <= x_r[j] - (y_r[j] >>> j);
          y_r[j+1] <= y_r[j] + (x_r[j] >>> j);
          z_r[j+1] <= z_r[j] - atan_w;
        end else begin
          x_r[j+1] <= x_r[j] + (y_r[j] >>> j);
          y_r[j+1] <= y_r[j] - (x_r[j] >>> j);
          z_r[j+1] <= z_r[j] + atan_w;
        end
        flip_r[j+1] <= flip_r[j];
      end
    end
  end

  // undo the fold by negation
  logic signed [31:0] sin_r;
  logic signed [31:0] cos_r;

  always_ff @(posedge clk) begin
    if (en_i[zyxe2t_pkg::ANG_LAT-1]) begin
      sin_r <= flip_r[N] ? 32'(-y_r[N]) : 32'(y_r[N]);
      cos_r <= flip_r[N] ? 32'(-x_r[N]) : 32'(x_r[N]);
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

FILE: design/zyx_euler_pose_to_transform_core.sv
// top level: zyx euler pose to rotation matrix and translation
//
// in_if carries one pose word: x, y, z position (mm, 16 fraction bits) and
// roll, pitch, yaw in degrees with 16 fraction bits. out_if returns one
// transform word per pose: the nine entries of Rz(yaw)*Ry(pitch)*Rx(roll)
// with MATRIX_FRAC_BITS fraction bits, clamped to +-1, and the position
// copied as tx, ty, tz. The constant bottom row is not sent.
// Both channels move a word when valid and ready are high at a clock edge.
// The pipeline runs through the degree to binary angle conversion stages,
// the cordic stages, one sign stage, then two multiply stages, one sum
// stage and the round and clamp stage that is the output register. A new
// pose is taken every cycle while in_if.ready is high; this rate is set
// by the one-stage-per-iteration cordic pipeline.
// When the receiver stalls, each stage holds only while the stage after it
// is full, so empty slots fill up and in_if.ready drops only once the whole
// pipeline is full. Reset (rst_n low, synchronous) empties the pipeline.
module zyx_euler_pose_to_transform_core (
  input  logic         clk,
  input  logic         rst_n,
  zyxe2t_pose_if.sink  in_if,
  zyxe2t_xform_if.source out_if
);

  localparam int L  = zyxe2t_pkg::PIPE_LAT;
  localparam int A  = zyxe2t_pkg::ANG_LAT;
  localparam int MW = zyxe2t_pkg::MAT_W;

  // stage valids and per-stage advance
  logic [L-1:0] v_r;
  logic [L-1:0] v_nxt;
  logic [L-1:0] en;

  assign en[L-1] = !v_r[L-1] || out_if.ready;
  for (genvar k = 0; k < L - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_if.valid;
    end
    for (int k = 1; k < L; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_if.ready = en[0];

  // position delay line
  zyxe2t_pkg::pos_t pos_r [0:L-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pos_r[0] <= '{x: in_if.pos_x, y: in_if.pos_y, z: in_if.pos_z};
    end
  end

  for (genvar k = 1; k < L; k++) begin : g_pos
    always_ff @(posedge clk) begin
      if (en[k]) begin
        pos_r[k] <= pos_r[k-1];
      end
    end
  end

  // sine and cosine of each angle
  logic signed [31:0] sr, cr, sp, cp, sy, cy;

  zyxe2t_angle u_roll (
    .clk(clk), .en_i(en[A-1:0]), .deg_i(in_if.roll_deg), .sin_o(sr), .cos_o(cr)
  );
  zyxe2t_angle u_pitch (
    .clk(clk), .en_i(en[A-1:0]), .deg_i(in_if.pitch_deg), .sin_o(sp), .cos_o(cp)
  );
  zyxe2t_angle u_yaw (
    .clk(clk), .en_i(en[A-1:0]), .deg_i(in_if.yaw_deg), .sin_o(sy), .cos_o(cy)
  );

  // stage m1: two-factor products, 60 fraction bits
  logic signed [63:0] cycp_1, sycp_1, cpsr_1, cpcr_1, cycr_1, cysr_1;
  logic signed [63:0] sycr_1, sysr_1, cysp_1, sysp_1;
  logic signed [31:0] sr_1, cr_1, sp_1;

  always_ff @(posedge clk) begin
    if (en[A]) begin
      cycp_1 <= 64'(cy) * 64'(cp);
      sycp_1 <= 64'(sy) * 64'(cp);
      cpsr_1 <= 64'(cp) * 64'(sr);
      cpcr_1 <= 64'(cp) * 64'(cr);
      cycr_1 <= 64'(cy) * 64'(cr);
      cysr_1 <= 64'(cy) * 64'(sr);
      sycr_1 <= 64'(sy) * 64'(cr);
      sysr_1 <= 64'(sy) * 64'(sr);
      cysp_1 <= 64'(cy) * 64'(sp);
      sysp_1 <= 64'(sy) * 64'(sp);
      sr_1   <= sr;
      cr_1   <= cr;
      sp_1   <= sp;
    end
  end

  // stage m2: floor the pair to 30 fraction bits, then third factor
  logic signed [31:0] cysp_w, sysp_w;
  logic signed [63:0] cyspsr_2, cyspcr_2, sypsr_2, sypcr_2;
  logic signed [63:0] cycp_2, sycp_2, cpsr_2, cpcr_2, cycr_2, cysr_2, sycr_2, sysr_2;
  logic signed [31:0] sp_2;

  assign cysp_w = cysp_1[61:30];
  assign sysp_w = sysp_1[61:30];

  always_ff @(posedge clk) begin
    if (en[A+1]) begin
      cyspsr_2 <= 64'(cysp_w) * 64'(sr_1);
      cyspcr_2 <= 64'(cysp_w) * 64'(cr_1);
      sypsr_2  <= 64'(sysp_w) * 64'(sr_1);
      sypcr_2  <= 64'(sysp_w) * 64'(cr_1);
      cycp_2   <= cycp_1;
      sycp_2   <= sycp_1;
      cpsr_2   <= cpsr_1;
      cpcr_2   <= cpcr_1;
      cycr_2   <= cycr_1;
      cysr_2   <= cysr_1;
      sycr_2   <= sycr_1;
      sysr_2   <= sysr_1;
      sp_2     <= sp_1;
    end
  end

  // stage m3: entry sums; the other entries are copied or, for m20, negated
  logic signed [63:0] e_r [0:8];

  always_ff @(posedge clk) begin
    if (en[A+2]) begin
      e_r[0] <= cycp_2;
      e_r[1] <= cyspsr_2 - sycr_2;
      e_r[2] <= cyspcr_2 + sysr_2;
      e_r[3] <= sycp_2;
      e_r[4] <= sypsr_2 + cycr_2;
      e_r[5] <= sypcr_2 - cysr_2;
      e_r[6] <= -(64'(sp_2) <<< 30);
      e_r[7] <= cpsr_2;
      e_r[8] <= cpcr_2;
    end
  end

  // stage m4: round and clamp into the output register
  logic [MW-1:0] m_r [0:8];

  for (genvar i = 0; i < 9; i++) begin : g_out
    always_ff @(posedge clk) begin
      if (en[L-1]) begin
        m_r[i] <= zyxe2t_pkg::to_entry(e_r[i]);
      end
    end
  end

  assign out_if.valid = v_r[L-1];
  assign out_if.m00   = m_r[0];
  assign out_if.m01   = m_r[1];
  assign out_if.m02   = m_r[2];
  assign out_if.m10   = m_r[3];
  assign out_if.m11   = m_r[4];
  assign out_if.m12   = m_r[5];
  assign out_if.m20   = m_r[6];
  assign out_if.m21   = m_r[7];
  assign out_if.m22   = m_r[8];
  assign out_if.tx    = pos_r[L-1].x;
  assign out_if.ty    = pos_r[L-1].y;
  assign out_if.tz    = pos_r[L-1].z;

endmodule

FILE: design/zyxe2t_checker.sv
// port-level checks for the euler pose to transform block, with bind
module zyxe2t_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [zyxe2t_pkg::MAT_W-1:0] m00,
  input logic signed [zyxe2t_pkg::MAT_W-1:0] m20
);

  localparam logic signed [zyxe2t_pkg::MAT_W-1:0] LIM =
    zyxe2t_pkg::MAT_LIM[zyxe2t_pkg::MAT_W-1:0];

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  // with no word waiting at the output the pipeline cannot be full
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output register is empty");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(m20))
    else $error("stalled result word changed");

  // entries m00 and m20 stay within plus and minus one
  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (m00 <= LIM) && (m00 >= -LIM) && (m20 <= LIM) && (m20 >= -LIM))
    else $error("matrix entry out of range");

endmodule

bind zyx_euler_pose_to_transform_core zyxe2t_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .m00       (out_if.m00),
  .m20       (out_if.m20)
);
